@@ design/qdec_pkg.sv @@
// Shared types and constants for the quadrature decoder with speed measurement.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qdec_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_DECODE_MODE = 2'd0;
    localparam logic [1:0] CFG_PULSES_PER_REV = 2'd1;
    localparam logic [1:0] CFG_WINDOW_MS = 2'd2;

    localparam logic [15:0] PPR_RESET = 16'd1024;
    localparam logic [15:0] WINDOW_RESET = 16'd100;

    // 60000 * 256 / 4: rpm scale in Q.8 with the x4 edge factor folded in
    localparam int SPEED_NUM_W = 22;
    localparam logic [SPEED_NUM_W-1:0] SPEED_NUM = 22'd3840000;

    localparam logic [32:0] LIMIT_POS = 33'h07FFFFFFF;
    localparam logic [32:0] LIMIT_NEG = 33'h080000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load_in;
        logic step;
        logic prep;
        logic mul;
        logic div;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic window;
        logic mul_last;
        logic div_last;
    } stat_t;

endpackage

`default_nettype wire

@@ design/qdec_ctrl.sv @@
// Sequencer for the decoder: input and output word handshakes and the speed steps.
// Depends on qdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdec_ctrl
    import qdec_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  wire   out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;
    logic   in_full_reg, in_full_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   step_go;
    logic   accept;

    assign out_free  = !out_valid_reg || out_ready;
    assign step_go   = (state_reg == ST_IDLE) && in_full_reg && out_free;
    // the held word can be replaced in the same cycle it is consumed
    assign in_ready  = !in_full_reg || step_go;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.load_in = accept;
        out_valid_next = out_valid_reg && !out_ready;
        in_full_next = accept ? 1'b1 : (step_go ? 1'b0 : in_full_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (step_go)
                begin
                    cmd.step = 1'b1;
                    if (stat.window)
                        state_next = ST_PREP;
                    else
                        out_valid_next = 1'b1;
                end
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                if (stat.mul_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div = 1'b1;
                if (stat.div_last)
                    state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                // output slot was checked free at step time and nothing else fills it
                cmd.finish = 1'b1;
                out_valid_next = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            in_full_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            in_full_reg <= in_full_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ design/qdec_datapath.sv @@
// Decoder datapath: edge decode, position and window counters, config registers,
// serial multiply and restoring divide for speed. Depends on qdec_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qdec_datapath
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire         [1:0]  cfg_index,
    input  wire         [15:0] cfg_data,
    input  wire                chan_a,
    input  wire                chan_b,
    input  wire                ms_tick,
    input  wire                clear_count,
    input  cmd_t               cmd,
    output stat_t              stat,
    output logic signed [31:0] position,
    output logic signed [31:0] speed_rpm_q8,
    output logic               speed_updated
);

    localparam int PW = COUNT_WIDTH + SPEED_NUM_W;
    localparam int MUL_CW = $clog2(SPEED_NUM_W);
    localparam int DIV_CW = $clog2(PW);

    // configuration
    logic        mode_reg;
    logic [15:0] ppr_reg;
    logic [15:0] window_reg;

    // held input word
    logic a_reg, b_reg, tick_reg, clr_reg;

    // decoder state
    logic [1:0]             last_ab_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [COUNT_WIDTH-1:0] cw_reg;
    logic [15:0]            elapsed_reg;
    logic [31:0]            speed_reg;

    // speed arithmetic
    logic [15:0]            el_latch_reg;
    logic [COUNT_WIDTH-1:0] mag_reg;
    logic                   neg_reg;
    logic [31:0]            div_reg;
    logic [PW-1:0]          acc_reg;
    logic [31:0]            rem_reg;
    logic [32:0]            quo_reg;
    logic                   ovf_reg;
    logic [MUL_CW-1:0]      mul_cnt_reg;
    logic [DIV_CW-1:0]      div_cnt_reg;

    // output word
    logic [31:0] pos_out_reg;
    logic [31:0] speed_out_reg;
    logic        upd_out_reg;

    logic [1:0]             cur_ab;
    logic [1:0]             diff_ab;
    logic                   inc, dec;
    logic [COUNT_WIDTH-1:0] count_new;
    logic [COUNT_WIDTH-1:0] cw_base;
    logic [COUNT_WIDTH-1:0] delta;
    logic [15:0]            el_inc;
    logic                   window;
    logic [31:0]            pos_step;
    logic [31:0]            pos_cur;
    logic [32:0]            shift_rem;
    logic                   ge;
    logic [32:0]            sub_rem;
    logic [32:0]            limit;
    logic [32:0]            mag_q;
    logic [31:0]            speed_calc;

    assign cur_ab  = {a_reg, b_reg};
    assign diff_ab = cur_ab ^ last_ab_reg;

    always_comb
    begin
        inc = 1'b0;
        dec = 1'b0;
        if (!mode_reg)
        begin
            // single-channel change only; direction from prev B against new A
            if (diff_ab == 2'b01 || diff_ab == 2'b10)
            begin
                dec = last_ab_reg[0] ^ cur_ab[1];
                inc = !(last_ab_reg[0] ^ cur_ab[1]);
            end
        end
        else
        begin
            inc = (last_ab_reg == 2'b11 && cur_ab == 2'b00)
               || (last_ab_reg == 2'b00 && cur_ab == 2'b11);
            dec = (last_ab_reg == 2'b10 && cur_ab == 2'b01)
               || (last_ab_reg == 2'b01 && cur_ab == 2'b10);
        end
    end

    always_comb
    begin
        if (clr_reg)
            count_new = '0;
        else if (inc)
            count_new = count_reg + COUNT_WIDTH'(1);
        else if (dec)
            count_new = count_reg - COUNT_WIDTH'(1);
        else
            count_new = count_reg;
    end

    assign cw_base = clr_reg ? '0 : cw_reg;
    assign delta   = count_new - cw_base;
    assign el_inc  = (elapsed_reg == 16'hFFFF) ? elapsed_reg : elapsed_reg + 16'd1;
    assign window  = tick_reg && (el_inc >= window_reg);

    generate
        if (COUNT_WIDTH >= 32)
        begin : g_pos_wide
            assign pos_step = count_new[31:0];
            assign pos_cur  = count_reg[31:0];
        end
        else
        begin : g_pos_narrow
            assign pos_step = {{(32-COUNT_WIDTH){count_new[COUNT_WIDTH-1]}}, count_new};
            assign pos_cur  = {{(32-COUNT_WIDTH){count_reg[COUNT_WIDTH-1]}}, count_reg};
        end
    endgenerate

    // one restoring-divide step per cycle, dividend bits taken from the top of acc
    assign shift_rem = {rem_reg, acc_reg[PW-1]};
    assign ge        = shift_rem >= {1'b0, div_reg};
    assign sub_rem   = shift_rem - {1'b0, div_reg};

    assign limit = neg_reg ? LIMIT_NEG : LIMIT_POS;
    assign mag_q = (ovf_reg || quo_reg > limit) ? limit : quo_reg;

    always_comb
    begin
        if (div_reg == 32'd0)
            speed_calc = 32'd0;
        else if (neg_reg)
            speed_calc = 32'd0 - mag_q[31:0];
        else
            speed_calc = mag_q[31:0];
    end

    assign stat.window   = window;
    assign stat.mul_last = (mul_cnt_reg == '0);
    assign stat.div_last = (div_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= 1'b0;
            ppr_reg     <= PPR_RESET;
            window_reg  <= WINDOW_RESET;
            last_ab_reg <= 2'b00;
            count_reg   <= '0;
            cw_reg      <= '0;
            elapsed_reg <= 16'd0;
            speed_reg   <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_DECODE_MODE:    mode_reg <= cfg_data[0];
                    CFG_PULSES_PER_REV: ppr_reg <= cfg_data;
                    CFG_WINDOW_MS:      window_reg <= cfg_data;
                    default:            ;
                endcase
            end
            if (cmd.step)
            begin
                last_ab_reg <= cur_ab;
                count_reg <= count_new;
                if (window)
                begin
                    cw_reg <= count_new;
                    elapsed_reg <= 16'd0;
                end
                else
                begin
                    cw_reg <= cw_base;
                    if (tick_reg)
                        elapsed_reg <= el_inc;
                end
            end
            if (cmd.finish)
                speed_reg <= speed_calc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            a_reg    <= chan_a;
            b_reg    <= chan_b;
            tick_reg <= ms_tick;
            clr_reg  <= clear_count;
        end
        if (cmd.step)
        begin
            el_latch_reg <= el_inc;
            neg_reg <= delta[COUNT_WIDTH-1];
            mag_reg <= delta[COUNT_WIDTH-1] ? (COUNT_WIDTH'(0) - delta) : delta;
            if (!window)
            begin
                pos_out_reg   <= pos_step;
                speed_out_reg <= speed_reg;
                upd_out_reg   <= 1'b0;
            end
        end
        if (cmd.prep)
        begin
            div_reg     <= 32'(ppr_reg) * 32'(el_latch_reg);
            acc_reg     <= '0;
            rem_reg     <= 32'd0;
            quo_reg     <= 33'd0;
            ovf_reg     <= 1'b0;
            mul_cnt_reg <= MUL_CW'(SPEED_NUM_W - 1);
            div_cnt_reg <= DIV_CW'(PW - 1);
        end
        if (cmd.mul)
        begin
            // MSB-first shift-add of mag * SPEED_NUM
            acc_reg <= {acc_reg[PW-2:0], 1'b0}
                     + (SPEED_NUM[mul_cnt_reg] ? {{SPEED_NUM_W{1'b0}}, mag_reg} : '0);
            mul_cnt_reg <= mul_cnt_reg - MUL_CW'(1);
        end
        if (cmd.div)
        begin
            acc_reg <= {acc_reg[PW-2:0], 1'b0};
            rem_reg <= ge ? sub_rem[31:0] : shift_rem[31:0];
            quo_reg <= {quo_reg[31:0], ge};
            ovf_reg <= ovf_reg | quo_reg[32];
            div_cnt_reg <= div_cnt_reg - DIV_CW'(1);
        end
        if (cmd.finish)
        begin
            pos_out_reg   <= pos_cur;
            speed_out_reg <= speed_calc;
            upd_out_reg   <= 1'b1;
        end
    end

    assign position      = pos_out_reg;
    assign speed_rpm_q8  = speed_out_reg;
    assign speed_updated = upd_out_reg;

endmodule

`default_nettype wire

@@ design/quadrature_decoder_with_speed.sv @@
// Top level of the quadrature decoder with windowed speed measurement.
// Depends on qdec_pkg, qdec_ctrl, qdec_datapath.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | chan_a, chan_b, ms_tick, clear_count
//  out     | out_valid/out_ready  | position, speed_rpm_q8, speed_updated
//  cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// Words that do not close a window stream one per clock while the output is not stalled.
// A word that closes a window runs the steps prep, bit-serial multiply, restoring divide
// and finish before its result is offered; the next word is not stepped until then.
// One input word is held while a result waits; a stalled output stalls the input after that.
// Reset clears position, window and speed state; config returns to its defaults.
`timescale 1ns / 1ps
`default_nettype none

module quadrature_decoder_with_speed
    import qdec_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                chan_a,
    input  wire                chan_b,
    input  wire                ms_tick,
    input  wire                clear_count,
    output logic               out_valid,
    input  wire                out_ready,
    output logic signed [31:0] position,
    output logic signed [31:0] speed_rpm_q8,
    output logic               speed_updated,
    input  wire                cfg_valid,
    output logic               cfg_ready,
    input  wire         [1:0]  cfg_index,
    input  wire         [15:0] cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    qdec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    qdec_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .chan_a        (chan_a),
        .chan_b        (chan_b),
        .ms_tick       (ms_tick),
        .clear_count   (clear_count),
        .cmd           (cmd),
        .stat          (stat),
        .position      (position),
        .speed_rpm_q8  (speed_rpm_q8),
        .speed_updated (speed_updated)
    );

endmodule

`default_nettype wire

@@ test/quadrature_decoder_with_speed_tb.sv @@
// Self-checking testbench for quadrature_decoder_with_speed: directed table, random phases, then spins.
// Depends on qdec_pkg and the design top; holds its own decoder and speed predictor.
`timescale 1ns / 1ps

module quadrature_decoder_with_speed_tb
    import qdec_pkg::*;
();

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 100;
    localparam longint unsigned RPM_SCALE = 64'd3840000;

    typedef struct packed {
        logic a;
        logic b;
        logic tick;
        logic clr;
    } pin_word_t;

    typedef struct packed {
        logic signed [31:0] position;
        logic signed [31:0] speed;
        logic               updated;
    } reading_t;

    typedef struct packed {
        pin_word_t s;
        logic      fixed;
        reading_t  r;
    } table_row_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic chan_a = 1'b0;
    logic chan_b = 1'b0;
    logic ms_tick = 1'b0;
    logic clear_count = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] position;
    logic signed [31:0] speed_rpm_q8;
    logic speed_updated;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    quadrature_decoder_with_speed u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .chan_a        (chan_a),
        .chan_b        (chan_b),
        .ms_tick       (ms_tick),
        .clear_count   (clear_count),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .position      (position),
        .speed_rpm_q8  (speed_rpm_q8),
        .speed_updated (speed_updated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // shadow config and predictor state
    logic        cfg_mode = 1'b0;
    logic [15:0] cfg_ppr = PPR_RESET;
    logic [15:0] cfg_window = WINDOW_RESET;
    logic [1:0]  prev_ab = '0;
    logic [31:0] pos_count = '0;
    logic [31:0] window_base = '0;
    logic [15:0] ms_in_window = '0;
    logic [31:0] speed_q8 = '0;

    reading_t expected_readings[$];
    table_row_t directed_rows[$];
    int fail_count = 0;
    int sender_idle_pct = 0;
    int receiver_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;

    // encoder generator state
    logic [1:0] gen_ab = '0;
    logic       gen_up = 1'b1;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] window_rpm_q8(input logic [31:0] delta,
                                                  input longint unsigned divisor);
        longint d;
        longint unsigned mag;
        longint unsigned q;
        longint unsigned cap;
        bit neg;
        d = longint'(signed'(delta));
        neg = (d < 0);
        mag = neg ? -d : d;
        q = (mag * RPM_SCALE) / divisor;
        cap = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
        if (q > cap)
            q = cap;
        if (neg)
            q = -q;
        return q[31:0];
    endfunction

    function automatic reading_t decode_sample(input pin_word_t s);
        reading_t r;
        logic [1:0] cur;
        logic [31:0] delta;
        int step;
        cur = {s.a, s.b};
        step = 0;
        if (!cfg_mode) begin
            if ((cur ^ prev_ab) == 2'b01 || (cur ^ prev_ab) == 2'b10)
                step = (prev_ab[0] ^ cur[1]) ? -1 : 1;
        end
        else begin
            if ((prev_ab == 2'b11 && cur == 2'b00) || (prev_ab == 2'b00 && cur == 2'b11))
                step = 1;
            else if ((prev_ab == 2'b10 && cur == 2'b01) || (prev_ab == 2'b01 && cur == 2'b10))
                step = -1;
        end
        prev_ab = cur;
        if (s.clr) begin
            pos_count = '0;
            window_base = '0;
        end
        else if (step > 0)
            pos_count = pos_count + 32'd1;
        else if (step < 0)
            pos_count = pos_count - 32'd1;
        r.updated = 1'b0;
        if (s.tick) begin
            if (ms_in_window != 16'hFFFF)
                ms_in_window = ms_in_window + 16'd1;
            if (ms_in_window >= cfg_window) begin
                delta = pos_count - window_base;
                if (cfg_ppr == 16'd0)
                    speed_q8 = '0;
                else
                    speed_q8 = window_rpm_q8(delta, longint'(cfg_ppr) * ms_in_window);
                window_base = pos_count;
                ms_in_window = '0;
                r.updated = 1'b1;
            end
        end
        r.position = pos_count;
        r.speed = speed_q8;
        return r;
    endfunction

    // one quarter step along the counting direction, or against it
    function automatic logic [1:0] gray_next(input logic [1:0] ab, input logic up);
        case (ab)
            2'b00:   return up ? 2'b01 : 2'b10;
            2'b01:   return up ? 2'b11 : 2'b00;
            2'b11:   return up ? 2'b10 : 2'b01;
            default: return up ? 2'b00 : 2'b11;
        endcase
    endfunction

    function automatic void add_row(input logic a, input logic b, input logic tick,
                                    input logic clr, input logic fixed, input int pos,
                                    input int spd, input logic upd);
        table_row_t row;
        row.s.a = a;
        row.s.b = b;
        row.s.tick = tick;
        row.s.clr = clr;
        row.fixed = fixed;
        row.r.position = pos;
        row.r.speed = spd;
        row.r.updated = upd;
        directed_rows.push_back(row);
    endfunction

    // called at a clock edge; returns at the edge where the word is taken
    task automatic send_sample(input pin_word_t s, input logic use_table,
                               input reading_t table_r);
        reading_t r;
        if ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        in_valid <= 1'b1;
        chan_a <= s.a;
        chan_b <= s.b;
        ms_tick <= s.tick;
        clear_count <= s.clr;
        do @(posedge clk); while (!in_ready);
        r = decode_sample(s);
        expected_readings.push_back(use_table ? table_r : r);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_DECODE_MODE:    cfg_mode = value[0];
            CFG_PULSES_PER_REV: cfg_ppr = value;
            CFG_WINDOW_MS:      cfg_window = value;
            default: ;
        endcase
    endtask

    task automatic configure(input logic mode, input logic [15:0] ppr, input logic [15:0] win);
        drain();
        write_reg(CFG_DECODE_MODE, {15'd0, mode});
        write_reg(CFG_PULSES_PER_REV, ppr);
        write_reg(CFG_WINDOW_MS, win);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // mostly legal quadrature motion, some jumps and clears
    task automatic run_random(input int count, input int tick_pct);
        pin_word_t s;
        int pick;
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(99);
            if (pick < 12)
                gen_ab = 2'($urandom_range(3));
            else if (cfg_mode && pick < 50)
                gen_ab = gen_ab ^ 2'b11;
            else begin
                if ($urandom_range(99) < 4)
                    gen_up = !gen_up;
                gen_ab = gray_next(gen_ab, gen_up);
            end
            s.a = gen_ab[1];
            s.b = gen_ab[0];
            s.tick = ($urandom_range(99) < tick_pct);
            s.clr = ($urandom_range(99) < 2);
            send_sample(s, 1'b0, '0);
        end
    endtask

    // steady rotation, then a tick word with no edge
    task automatic spin(input logic up, input int steps, input logic tick_each);
        pin_word_t s;
        s.clr = 1'b0;
        for (int i = 0; i < steps; i++) begin
            gen_ab = gray_next(gen_ab, up);
            s.a = gen_ab[1];
            s.b = gen_ab[0];
            s.tick = tick_each;
            send_sample(s, 1'b0, '0);
        end
        s.tick = 1'b1;
        send_sample(s, 1'b0, '0);
    endtask

    // receiver: random stalls plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_seq != hold_seen) begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk) begin : result_check
        reading_t want;
        if (rst_n && out_valid && out_ready) begin
            if (expected_readings.size() == 0) begin
                $error("unexpected output word: position %0d", position);
                fail_count++;
            end
            else begin
                want = expected_readings.pop_front();
                if (position !== want.position) begin
                    $error("position: expected %0d, got %0d", want.position, position);
                    fail_count++;
                end
                if (speed_rpm_q8 !== want.speed) begin
                    $error("speed_rpm_q8: expected %0d, got %0d", want.speed, speed_rpm_q8);
                    fail_count++;
                end
                if (speed_updated !== want.updated) begin
                    $error("speed_updated: expected %0b, got %0b", want.updated, speed_updated);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("** quadrature_decoder_with_speed: FAILED **");
        $finish;
    end

    initial begin
        // defaults after reset: single-channel-change decoding, PPR_RESET lines, WINDOW_RESET window
        add_row(0, 0, 0, 0, 1, 0, 0, 0);
        add_row(0, 1, 0, 0, 1, 1, 0, 0);
        add_row(1, 1, 0, 0, 1, 2, 0, 0);
        add_row(1, 0, 0, 0, 1, 3, 0, 0);
        add_row(0, 0, 0, 0, 1, 4, 0, 0);
        add_row(1, 0, 0, 0, 1, 3, 0, 0);
        add_row(1, 1, 0, 0, 1, 2, 0, 0);
        // both channels change: ignored
        add_row(0, 0, 0, 0, 1, 2, 0, 0);
        add_row(1, 1, 0, 0, 1, 2, 0, 0);
        add_row(1, 1, 0, 1, 1, 0, 0, 0);
        // clear drops the edge of the same word
        add_row(1, 0, 0, 1, 1, 0, 0, 0);
        add_row(0, 0, 1, 0, 1, 1, 0, 0);
        add_row(0, 1, 1, 1, 1, 0, 0, 0);
        add_row(1, 1, 1, 0, 0, 0, 0, 0);
        add_row(1, 0, 1, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0);
        add_row(0, 1, 0, 0, 0, 0, 0, 0);
        add_row(0, 0, 0, 0, 0, 0, 0, 0);
        add_row(1, 1, 1, 1, 0, 0, 0, 0);
        add_row(0, 0, 1, 0, 0, 0, 0, 0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 28;
        receiver_idle_pct = 68;
        foreach (directed_rows[i])
            send_sample(directed_rows[i].s, directed_rows[i].fixed, directed_rows[i].r);
        gen_ab = 2'b00;

        configure(1'b0, PPR_RESET, 16'd10);
        hold_seq <= hold_seq + 1;
        run_random(70, 50);
        configure(1'b1, 16'd1, 16'd1);
        run_random(60, 30);

        sender_idle_pct = 68;
        receiver_idle_pct = 28;
        configure(1'b0, 16'd65535, 16'd3);
        run_random(40, 40);
        // zero lines per revolution: speed reads zero
        configure(1'b1, 16'd0, 16'd5);
        run_random(40, 40);
        // zero window: every tick closes
        configure(1'b0, 16'd7, 16'd0);
        run_random(40, 30);

        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        // short window and one line: speed saturates both ways
        configure(1'b0, 16'd1, 16'd1);
        spin(1'b1, 1, 1'b1);
        spin(1'b1, 560, 1'b0);
        spin(1'b0, 560, 1'b0);
        // most lines per revolution: large divisor
        configure(1'b0, 16'd65535, 16'd30);
        spin(1'b1, 30, 1'b1);

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_readings.size() != 0) begin
            $error("%0d expected output words never arrived", expected_readings.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** quadrature_decoder_with_speed: PASSED **");
        else
            $display("** quadrature_decoder_with_speed: FAILED **");
        $finish;
    end

endmodule
